FILE: rtl/mpb_pkg.sv
// shared types and constants for the midi pitch bend parser
`default_nettype none

package mpb_pkg;

  localparam int unsigned VALUE_W = 10;
  localparam int unsigned BEND_W  = 16;
  localparam int unsigned CHAN_W  = 5;
  localparam int unsigned SEL_W   = 5;
  localparam int unsigned RAW_W   = 14;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_SELECT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RAW_OUTPUT     = 1'b1;

  localparam logic [SEL_W-1:0] SEL_OMNI     = 5'd0;
  localparam logic [SEL_W-1:0] SEL_MAX      = 5'd16;
  localparam logic [3:0]       KIND_BEND    = 4'hE;
  localparam logic [4:0]       KIND_REALTIME = 5'b11111;

  localparam logic [15:0] ROUND_BIAS = 16'd4095;
  localparam logic [15:0] DIVISOR    = 16'd8191;
  localparam logic [15:0] DIVISOR_X2 = 16'd16382;
  localparam logic [15:0] CLAMP_MAG  = 16'd16384;

  typedef struct packed {
    logic [BEND_W-1:0] bend_value;
    logic [CHAN_W-1:0] channel_number;
    logic              channel_valid;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/midi_pitch_bend_parser_core.sv
// top level: midi pitch bend message parser with selectable channel
// path: a value is registered in the input register on acceptance; its result
//   is registered in the output register once that is free and is presented from it
// throughput: one input value per cycle; the input register advances
//   whenever the output register is free or being drained
// reset: async active low, clears valid flags and configuration, returns parser state to omni
`default_nettype none

module midi_pitch_bend_parser_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,

  input  wire logic                          cfg_we_i,
  input  wire logic [mpb_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [mpb_pkg::SEL_W-1:0]     cfg_data_i,

  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic signed [mpb_pkg::VALUE_W-1:0] in_value_i,

  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic signed [mpb_pkg::BEND_W-1:0]  bend_value_o,
  output logic [mpb_pkg::CHAN_W-1:0]         channel_number_o,
  output logic                               channel_valid_o
);

  logic [mpb_pkg::SEL_W-1:0] channel_select_q;
  logic                      raw_output_q;

  logic                        s1_valid_q;
  logic [mpb_pkg::VALUE_W-1:0] s1_value_q;
  logic                        s1_adv;
  logic                        s1_fire;

  logic [mpb_pkg::SEL_W-1:0] applied_sel_q, applied_sel_d;
  logic                      omni_q, omni_d;
  logic [3:0]                listen_q, listen_d;
  logic                      matched_q, matched_d;
  logic                      held_q, held_d;
  logic [6:0]                low_q, low_d;

  logic                      emit;
  logic [mpb_pkg::BEND_W-1:0] bend_scaled;
  logic [mpb_pkg::RAW_W-1:0]  bend_raw;

  mpb_pkg::result_t result_d;
  mpb_pkg::result_t result_q;
  logic             out_valid_q, out_valid_d;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channel_select_q <= '0;
      raw_output_q     <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mpb_pkg::CFG_CHANNEL_SELECT: channel_select_q <= cfg_data_i;
        mpb_pkg::CFG_RAW_OUTPUT:     raw_output_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // input register
  assign s1_adv     = !out_valid_q || out_ready_i;
  assign s1_fire    = s1_valid_q && s1_adv;
  assign in_ready_o = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_value_q <= in_value_i;
    end
  end

  // parser step
  always_comb begin
    applied_sel_d = applied_sel_q;
    omni_d        = omni_q;
    listen_d      = listen_q;
    matched_d     = matched_q;
    held_d        = held_q;
    low_d         = low_q;
    emit          = 1'b0;

    if (s1_fire && !s1_value_q[9]) begin
      if ((channel_select_q != applied_sel_q) && (channel_select_q <= mpb_pkg::SEL_MAX)) begin
        applied_sel_d = channel_select_q;
        if (channel_select_q == mpb_pkg::SEL_OMNI) begin
          omni_d = 1'b1;
        end else begin
          omni_d   = 1'b0;
          listen_d = 4'(channel_select_q - 5'd1);
        end
      end

      if (s1_value_q[8]) begin
        matched_d = 1'b0;
        held_d    = 1'b0;
      end else if (s1_value_q[7]) begin
        if (s1_value_q[7:3] == mpb_pkg::KIND_REALTIME) begin
          // realtime bytes leave running status alone
        end else if (s1_value_q[7:4] == mpb_pkg::KIND_BEND) begin
          if (omni_d) begin
            listen_d = s1_value_q[3:0];
          end
          matched_d = omni_d || (listen_d == s1_value_q[3:0]);
          held_d    = 1'b0;
        end else begin
          matched_d = 1'b0;
          held_d    = 1'b0;
        end
      end else if (held_q) begin
        emit   = 1'b1;
        held_d = 1'b0;
      end else if (matched_q) begin
        low_d  = s1_value_q[6:0];
        held_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      applied_sel_q <= '0;
      omni_q        <= 1'b1;
      listen_q      <= '0;
      matched_q     <= 1'b0;
      held_q        <= 1'b0;
      low_q         <= '0;
    end else begin
      applied_sel_q <= applied_sel_d;
      omni_q        <= omni_d;
      listen_q      <= listen_d;
      matched_q     <= matched_d;
      held_q        <= held_d;
      low_q         <= low_d;
    end
  end

  assign bend_raw = {s1_value_q[6:0], low_q};

  mpb_bend_scale u_scale (
    .bend_raw_i   (bend_raw),
    .raw_output_i (raw_output_q),
    .bend_value_o (bend_scaled)
  );

  always_comb begin
    result_d.bend_value     = bend_scaled;
    result_d.channel_number = omni_d ? ({1'b0, listen_d} + 5'd1) : '0;
    result_d.channel_valid  = omni_d;
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_fire) begin
      out_valid_d = emit;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign bend_value_o     = result_q.bend_value;
  assign channel_number_o = result_q.channel_number;
  assign channel_valid_o  = result_q.channel_valid;

  // checks
  a_held_needs_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q |-> matched_q)
    else $error("low byte held without matched status");

  a_omni_channel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && channel_valid_o) |-> (channel_number_o != 5'd0))
    else $error("omni result without channel number");

  a_single_channel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !channel_valid_o) |-> (channel_number_o == 5'd0))
    else $error("channel number reported outside omni mode");

  a_bend_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((bend_value_o >= -16'sd16384) && (bend_value_o <= 16'sd16384)))
    else $error("bend value out of range");

endmodule

`default_nettype wire

FILE: rtl/mpb_bend_scale.sv
// raw or normalized q1.14 bend from a 14-bit pitch bend word
`default_nettype none

module mpb_bend_scale (
  input  wire logic [mpb_pkg::RAW_W-1:0]  bend_raw_i,
  input  wire logic                       raw_output_i,
  output logic      [mpb_pkg::BEND_W-1:0] bend_value_o
);

  logic        neg;
  logic [13:0] dev;
  logic [13:0] mag;
  logic [15:0] mag_x2;
  logic [15:0] biased;
  logic [15:0] q_mag;
  logic [15:0] scaled;

  // signed offset from center is the word with its top bit flipped
  assign neg    = ~bend_raw_i[13];
  assign dev    = {~bend_raw_i[13], bend_raw_i[12:0]};
  assign mag    = neg ? (14'd0 - dev) : dev;
  assign mag_x2 = {1'b0, mag, 1'b0};
  assign biased = mag_x2 + mpb_pkg::ROUND_BIAS;

  // 16384/8191 = 2 + 2/8191, so the quotient is 2|d| plus a small correction
  always_comb begin
    q_mag = mag_x2;
    if (biased >= mpb_pkg::DIVISOR) begin
      q_mag = q_mag + 16'd1;
    end
    if (biased >= mpb_pkg::DIVISOR_X2) begin
      q_mag = q_mag + 16'd1;
    end
    if (neg && (q_mag > mpb_pkg::CLAMP_MAG)) begin
      q_mag = mpb_pkg::CLAMP_MAG;
    end
    scaled = neg ? (16'd0 - q_mag) : q_mag;
  end

  assign bend_value_o = raw_output_i ? {2'b00, bend_raw_i} : scaled;

endmodule

`default_nettype wire

FILE: tb/sv/tb_midi_pitch_bend_parser_core.sv
// self-checking testbench for the midi pitch bend parser core
`timescale 1ns / 100ps

module tb_midi_pitch_bend_parser_core;

  localparam logic [7:0] NOTE_OFF     = 8'h80;
  localparam logic [7:0] NOTE_ON      = 8'h90;
  localparam logic [7:0] BEND_STATUS  = 8'hE0;
  localparam logic [7:0] SYSEX_START  = 8'hF0;
  localparam logic [7:0] SYSEX_END    = 8'hF7;
  localparam logic [7:0] TIMING_CLOCK = 8'hF8;
  localparam logic [7:0] SYSTEM_RESET = 8'hFF;
  localparam int DATA_MAX     = 127;
  localparam int VALUE_CLEAR  = 256;
  localparam int VALUE_TOP    = 511;
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_CYCLES  = 300;
  localparam int NUM_BLOCKS   = 6;
  localparam int BLOCK_VALUES = 80;
  localparam int SEL_PLAN [NUM_BLOCKS] = '{0, 16, 1, 31, 0, 0};
  localparam int RAW_PLAN [NUM_BLOCKS] = '{0, 1, 0, 1, 1, 0};

  typedef enum logic [1:0] {ROW_ITEM, ROW_SET_CHANNEL, ROW_SET_RAW} row_kind_e;
  typedef enum logic [1:0] {CHK_NONE, CHK_GIVEN, CHK_PREDICTED} row_check_e;

  typedef struct packed {
    row_kind_e          kind;
    logic signed [15:0] value;
    row_check_e         chk;
    logic signed [15:0] bend;
    logic [4:0]         chan;
    logic               chan_ok;
  } row_t;

  localparam int NUM_ROWS = 48;
  localparam row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{ROW_ITEM, 8'h12, CHK_NONE, 0, 0, 0},
    '{ROW_ITEM, BEND_STATUS, CHK_NONE, 0, 0, 0},
    '{ROW_ITEM, 0, CHK_NONE, 0, 0, 0},
    '{ROW_ITEM, 0, CHK_GIVEN, -16384, 1, 1},
    '{ROW_ITEM, DATA_MAX, CHK_NONE, 0, 0, 0},
    '{ROW_ITEM, DATA_MAX, CHK_GIVEN, 16384, 1, 1},
    '{ROW_ITEM, BEND_STATUS | 8'd15, CHK_NONE, 0, 0, 0},
    '{ROW_ITEM, 0, CHK_NONE, 0, 0, 0},
    '{ROW_ITEM, 8'h40, CHK_GIVEN, 0, 16, 1},
    '{ROW_ITEM, BEND_STATUS | 8'd3, CHK_NONE, 0, 0, 0},
    '{ROW_ITEM, 8'h10, CHK_NONE, 0, 0, 0},
    '{ROW_ITEM, -1, CHK_NONE, 0, 0, 0},
    '{ROW_ITEM, TIMING_CLOCK, CHK_NONE, 0, 0, 0},
    '{ROW_ITEM, SYSTEM_RESET, CHK_NONE, 0, 0, 0},
    '{ROW_ITEM, 8'h40, CHK_PREDICTED, 0, 0, 0},
    '{ROW_ITEM, SYSEX_START, CHK_NONE, 0, 0, 0},
    '{ROW_ITEM, 8'h2B, CHK_NONE, 0, 0, 0},
    '{ROW_ITEM, BEND_STATUS | 8'd5, CHK_NONE, 0, 0, 0},
    '{ROW_ITEM, 8'h01, CHK_NONE, 0, 0, 0},
    '{ROW_ITEM, VALUE_CLEAR, CHK_NONE, 0, 0, 0},
    '{ROW_ITEM, 8'h02, CHK_NONE, 0, 0, 0},
    '{ROW_ITEM, BEND_STATUS | 8'd5, CHK_NONE, 0, 0, 0},
    '{ROW_ITEM, NOTE_ON, CHK_NONE, 0, 0, 0},
    '{ROW_ITEM, 8'h01, CHK_NONE, 0, 0, 0},
    '{ROW_ITEM, VALUE_TOP, CHK_NONE, 0, 0, 0},
    '{ROW_ITEM, -256, CHK_NONE, 0, 0, 0},
    '{ROW_SET_RAW, 1, CHK_NONE, 0, 0, 0},
    '{ROW_ITEM, BEND_STATUS | 8'd5, CHK_NONE, 0, 0, 0},
    '{ROW_ITEM, DATA_MAX, CHK_NONE, 0, 0, 0},
    '{ROW_ITEM, DATA_MAX, CHK_GIVEN, 16383, 6, 1},
    '{ROW_SET_CHANNEL, 3, CHK_NONE, 0, 0, 0},
    '{ROW_ITEM, BEND_STATUS | 8'd2, CHK_NONE, 0, 0, 0},
    '{ROW_ITEM, 5, CHK_NONE, 0, 0, 0},
    '{ROW_ITEM, 6, CHK_GIVEN, 773, 0, 0},
    '{ROW_ITEM, BEND_STATUS | 8'd7, CHK_NONE, 0, 0, 0},
    '{ROW_ITEM, 1, CHK_NONE, 0, 0, 0},
    '{ROW_ITEM, 2, CHK_NONE, 0, 0, 0},
    '{ROW_SET_CHANNEL, 20, CHK_NONE, 0, 0, 0},
    '{ROW_ITEM, BEND_STATUS | 8'd2, CHK_NONE, 0, 0, 0},
    '{ROW_ITEM, 0, CHK_NONE, 0, 0, 0},
    '{ROW_ITEM, 0, CHK_GIVEN, 0, 0, 0},
    '{ROW_SET_CHANNEL, 16, CHK_NONE, 0, 0, 0},
    '{ROW_SET_RAW, 0, CHK_NONE, 0, 0, 0},
    '{ROW_ITEM, BEND_STATUS | 8'd15, CHK_NONE, 0, 0, 0},
    '{ROW_ITEM, 8'h55, CHK_NONE, 0, 0, 0},
    '{ROW_ITEM, 8'h2A, CHK_PREDICTED, 0, 0, 0},
    '{ROW_ITEM, SYSEX_END, CHK_NONE, 0, 0, 0},
    '{ROW_ITEM, NOTE_OFF, CHK_NONE, 0, 0, 0}
  };

  logic                               clk_i       = 1'b0;
  logic                               rst_ni      = 1'b0;
  logic                               cfg_we_i    = 1'b0;
  logic [mpb_pkg::CFG_IDX_W-1:0]      cfg_idx_i   = '0;
  logic [mpb_pkg::SEL_W-1:0]          cfg_data_i  = '0;
  logic                               in_valid_i  = 1'b0;
  logic                               in_ready_o;
  logic signed [mpb_pkg::VALUE_W-1:0] in_value_i  = '0;
  logic                               out_valid_o;
  logic                               out_ready_i = 1'b0;
  logic signed [mpb_pkg::BEND_W-1:0]  bend_value_o;
  logic [mpb_pkg::CHAN_W-1:0]         channel_number_o;
  logic                               channel_valid_o;

  midi_pitch_bend_parser_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .in_value_i      (in_value_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .bend_value_o    (bend_value_o),
    .channel_number_o(channel_number_o),
    .channel_valid_o (channel_valid_o)
  );

  always #5 clk_i = ~clk_i;

  // parser mirror
  logic [mpb_pkg::SEL_W-1:0] sel_cfg     = mpb_pkg::SEL_OMNI;
  logic                      raw_cfg     = 1'b0;
  logic [mpb_pkg::SEL_W-1:0] sel_applied = mpb_pkg::SEL_OMNI;
  logic                      omni_on     = 1'b1;
  logic [3:0]                chan_heard  = '0;
  logic                      bend_armed  = 1'b0;
  logic                      lsb_held    = 1'b0;
  logic [6:0]                lsb_bits    = '0;

  mpb_pkg::result_t pending_bends[$];
  bit      hand_checked   = 1'b0;
  int      send_idle_pct  = 0;
  int      recv_idle_pct  = 0;
  int      hold_requests  = 0;
  int      values_sent    = 0;
  int      bends_checked  = 0;
  int      errors         = 0;

  function automatic int to_q14(input logic [13:0] b);
    int d;
    int n;
    int q;
    d = int'(b) - 8192;
    n = d * 16384;
    if (n >= 0) q = (n + 4095) / 8191;
    else q = -((-n + 4095) / 8191);
    if (q < -16384) q = -16384;
    return q;
  endfunction

  task automatic track_value(input logic [mpb_pkg::VALUE_W-1:0] v, output bit emitted,
                             output mpb_pkg::result_t res);
    logic [13:0] b;
    emitted = 1'b0;
    res = '0;
    if (v[9]) return;
    if (sel_cfg != sel_applied && sel_cfg <= mpb_pkg::SEL_MAX) begin
      sel_applied = sel_cfg;
      if (sel_cfg == mpb_pkg::SEL_OMNI) begin
        omni_on = 1'b1;
      end else begin
        omni_on = 1'b0;
        chan_heard = 4'(sel_cfg - 5'd1);
      end
    end
    if (v[8]) begin
      bend_armed = 1'b0;
      lsb_held = 1'b0;
      return;
    end
    if (v[7]) begin
      if (v[7:4] == mpb_pkg::KIND_BEND) begin
        if (omni_on) chan_heard = v[3:0];
        bend_armed = (chan_heard == v[3:0]);
        lsb_held = 1'b0;
      end else if (v[7:0] < TIMING_CLOCK) begin
        bend_armed = 1'b0;
        lsb_held = 1'b0;
      end
      return;
    end
    if (lsb_held) begin
      b = {v[6:0], lsb_bits};
      res.bend_value = raw_cfg ? 16'(b) : 16'(to_q14(b));
      res.channel_number = omni_on ? {1'b0, chan_heard} + 5'd1 : 5'd0;
      res.channel_valid = omni_on;
      lsb_held = 1'b0;
      emitted = 1'b1;
    end else if (bend_armed) begin
      lsb_bits = v[6:0];
      lsb_held = 1'b1;
    end
  endtask

  task automatic send_value(input int v);
    bit               emitted;
    mpb_pkg::result_t res;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_value_i <= v[mpb_pkg::VALUE_W-1:0];
    do @(posedge clk_i); while (!in_ready_o);
    values_sent++;
    track_value(v[mpb_pkg::VALUE_W-1:0], emitted, res);
    if (emitted && !hand_checked) pending_bends.push_back(res);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_bends.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [mpb_pkg::CFG_IDX_W-1:0] idx, input int data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data[mpb_pkg::SEL_W-1:0];
    @(posedge clk_i);
    if (idx == mpb_pkg::CFG_CHANNEL_SELECT) sel_cfg = data[mpb_pkg::SEL_W-1:0];
    else raw_cfg = data[0];
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_data_byte();
    int r;
    int pick;
    r = $urandom_range(99);
    if (r < 6) send_value($urandom_range(TIMING_CLOCK, SYSTEM_RESET));
    else if (r < 9) send_value(-int'($urandom_range(1, 256)));
    else if (r < 11) send_value($urandom_range(NOTE_OFF, SYSEX_END));
    else if (r < 12) send_value($urandom_range(VALUE_CLEAR, VALUE_TOP));
    pick = $urandom_range(9);
    send_value(pick == 0 ? 0 : pick == 1 ? DATA_MAX : $urandom_range(DATA_MAX));
  endtask

  task automatic send_bend_message();
    int ch;
    if (!omni_on && $urandom_range(3) != 0) ch = chan_heard;
    else ch = $urandom_range(15);
    send_value(BEND_STATUS | ch);
    repeat ($urandom_range(1, 3)) begin
      send_data_byte();
      send_data_byte();
    end
  endtask

  // result side: random stalls, long hold on request, checks each transaction
  int hold_seen = 0;
  int hold_left = 0;
  always @(posedge clk_i) begin
    mpb_pkg::result_t want;
    if (out_valid_o && out_ready_i) begin
      bends_checked++;
      if (pending_bends.size() == 0) begin
        $error("unexpected bend: bend_value %0d channel_number %0d", bend_value_o,
               channel_number_o);
        errors++;
      end else begin
        want = pending_bends.pop_front();
        if (bend_value_o !== want.bend_value) begin
          $error("bend_value: expected %0d, actual %0d", $signed(want.bend_value),
                 bend_value_o);
          errors++;
        end
        if (channel_number_o !== want.channel_number) begin
          $error("channel_number: expected %0d, actual %0d", want.channel_number,
                 channel_number_o);
          errors++;
        end
        if (channel_valid_o !== want.channel_valid) begin
          $error("channel_valid: expected %0d, actual %0d", want.channel_valid,
                 channel_valid_o);
          errors++;
        end
      end
    end
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end

  initial begin
    row_t row;
    int   target;
    bit   paused;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NUM_ROWS; i++) begin
      row = DIRECTED_ROWS[i];
      case (row.kind)
        ROW_SET_CHANNEL: begin
          wait_idle();
          write_reg(mpb_pkg::CFG_CHANNEL_SELECT, row.value);
        end
        ROW_SET_RAW: begin
          wait_idle();
          write_reg(mpb_pkg::CFG_RAW_OUTPUT, row.value);
        end
        default: begin
          hand_checked = (row.chk != CHK_PREDICTED);
          send_value(row.value);
          if (row.chk == CHK_GIVEN)
            pending_bends.push_back(mpb_pkg::result_t'{row.bend, row.chan, row.chan_ok});
        end
      endcase
    end
    hand_checked = 1'b0;

    for (int blk = 0; blk < NUM_BLOCKS; blk++) begin
      wait_idle();
      write_reg(mpb_pkg::CFG_CHANNEL_SELECT,
                (blk == NUM_BLOCKS - 1) ? $urandom_range(1, 15) : SEL_PLAN[blk]);
      write_reg(mpb_pkg::CFG_RAW_OUTPUT, RAW_PLAN[blk]);
      send_idle_pct = (blk < 2) ? 30 : (blk < 4) ? 69 : 0;
      recv_idle_pct = (blk < 2) ? 69 : (blk < 4) ? 30 : 0;
      // block fills while the result side holds off
      if (blk == 4) hold_requests++;
      paused = 1'b0;
      target = values_sent + BLOCK_VALUES;
      while (values_sent < target) begin
        if (blk == 4 && !paused && values_sent >= target - BLOCK_VALUES / 2) begin
          wait_idle();
          paused = 1'b1;
        end
        if ($urandom_range(99) < 80) send_bend_message();
        else send_value($urandom_range(0, 1023));
      end
    end

    wait_idle();
    $display("sent %0d values, compared %0d bends", values_sent, bends_checked);
    $display("covered omni and single channel, ignored selects, raw and q1.14 output");
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
